// ----- design/bqp_pkg.sv -----
`timescale 1ns / 1ps
// bqp_pkg: shared types and constants for the box qp 2x2 solver
// no dependencies; used by every other file of the block

package bqp_pkg;

    localparam int DATA_W      = 32;
    localparam int WIDE_W      = 97;   // width that holds the shifted numerators and exactly fits det*bound
    localparam int DEN_W       = 65;   // signed divisor: determinant or a diagonal entry
    localparam int DEN_MAG_W   = 65;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_LAT     = DIV_STEPS + 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic signed [DATA_W-1:0] LOWER_RESET = 32'sd0;
    localparam logic signed [DATA_W-1:0] UPPER_RESET = 32'sd65536;
    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [DEN_W-1:0]  den_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER = 2'd0,
        REG_UPPER = 2'd1
    } reg_idx_t;

    typedef enum logic [3:0] {
        KKT_LO_LO    = 4'd0,
        KKT_FR_LO    = 4'd1,
        KKT_UP_LO    = 4'd2,
        KKT_LO_FR    = 4'd3,
        KKT_INTERIOR = 4'd4,
        KKT_UP_FR    = 4'd5,
        KKT_LO_UP    = 4'd6,
        KKT_FR_UP    = 4'd7,
        KKT_UP_UP    = 4'd8
    } kkt_t;

    // what travels alongside the dividers
    typedef struct packed {
        logic              singular;
        kkt_t              code;
        logic              div1;
        logic              div2;
        logic [DATA_W-1:0] x1_fix;
        logic [DATA_W-1:0] x2_fix;
    } tag_t;

    // one classified word in the queue
    typedef struct packed {
        tag_t  tag;
        wide_t num1;
        den_t  den1;
        wide_t num2;
        den_t  den2;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic signed [63:0] mul_32x32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [63:0] ae;
        logic signed [63:0] be;
        ae = 64'(a);
        be = 64'(b);
        return ae * be;
    endfunction

    function automatic logic signed [64:0] mul_33x32(input logic signed [32:0] a,
                                                     input logic signed [31:0] b);
        logic signed [64:0] ae;
        logic signed [64:0] be;
        ae = 65'(a);
        be = 65'(b);
        return ae * be;
    endfunction

endpackage

// ----- design/bqp_ifs.sv -----
`timescale 1ns / 1ps
// bqp_ifs: valid/ready channels of the solver (subproblem, solution, register write)
// depends on bqp_pkg

interface bqp_item_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       diag_first;
    logic signed [31:0]       off_diag;
    logic signed [31:0]       diag_second;
    logic signed [31:0]       rhs_first;
    logic signed [31:0]       rhs_second;

    modport source (output valid, diag_first, off_diag, diag_second, rhs_first,
                    rhs_second, input ready);
    modport sink (input valid, diag_first, off_diag, diag_second, rhs_first,
                  rhs_second, output ready);
endinterface

interface bqp_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_first;
    logic signed [31:0] x_second;
    logic [3:0]         case_code;
    logic               singular;

    modport source (output valid, x_first, x_second, case_code, singular, input ready);
    modport sink (input valid, x_first, x_second, case_code, singular, output ready);
endinterface

interface bqp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bqp_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/box_qp_two_by_two_solver_unit.sv -----
`timescale 1ns / 1ps
// box_qp_two_by_two_solver_unit: top level of the box constrained 2x2 qp solver
// depends on bqp_pkg, bqp_ifs, bqp_front, bqp_queue, bqp_back
//
//  channel      role    word
//  subproblem   sink    a11, a12, a22, b1, b2 (signed q16.16)
//  solution     source  x1, x2 (saturated), case code, singular flag
//  regs         sink    index 0 lower bound, index 1 upper bound
//
// one subproblem word per cycle is taken when nothing stalls; a word shows up
// on solution after the 3 front stages, the queue and the 35 divider stages
// the two divider pipelines run side by side; throughput stays one per cycle while nothing stalls
// reset: bounds go to 0 and 1.0, queue and pipelines empty
// a stalled solution halts the back end; the front keeps filling the 4-word queue,
// then drops subproblem.ready

module box_qp_two_by_two_solver_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    bqp_item_if.sink      subproblem,
    bqp_result_if.source  solution,
    bqp_cfg_if.sink       regs
);
    import bqp_pkg::*;

    logic signed [DATA_W-1:0] lower_reg, upper_reg;
    q_stat_t                  q_stat;
    cmd_t                     wr_cmd, rd_cmd;
    logic                     push, pop;

    // register port never stalls; the user must write only while the unit is idle, the block does not enforce it
    assign regs.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lower_reg <= LOWER_RESET;
            upper_reg <= UPPER_RESET;
        end else if (regs.valid) begin
            unique case (reg_idx_t'(regs.index))
                REG_LOWER: lower_reg <= regs.data;
                REG_UPPER: upper_reg <= regs.data;
                default:   ;   // unmapped index, ignored
            endcase
        end
    end

    // front: products, sums, compares, case selection
    bqp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .subproblem (subproblem),
        .lower      (lower_reg),
        .upper      (upper_reg),
        .q_stat     (q_stat),
        .push       (push),
        .cmd        (wr_cmd)
    );

    // decouples the front from a stalled back end
    bqp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .rd_cmd (rd_cmd),
        .stat   (q_stat)
    );

    // back: two dividers and the solution word
    bqp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head     (rd_cmd),
        .pop      (pop),
        .solution (solution)
    );

endmodule

// ----- design/bqp_front.sv -----
`timescale 1ns / 1ps
// bqp_front: products, sums and kkt classification of one subproblem word
// depends on bqp_pkg and bqp_ifs; feeds bqp_queue

module bqp_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bqp_item_if.sink             subproblem,
    input  logic signed [31:0]   lower,
    input  logic signed [31:0]   upper,
    input  bqp_pkg::q_stat_t     q_stat,
    output logic                 push,
    output bqp_pkg::cmd_t        cmd
);
    import bqp_pkg::*;

    logic en;
    logic v1_reg, v2_reg, v3_reg;

    // stage 1: products
    logic signed [63:0] p11_22_reg, p12_12_reg, p22_b1_reg, p12_b2_reg;
    logic signed [63:0] p11_b2_reg, p12_b1_reg;
    logic signed [63:0] p11_lo_reg, p12_lo_reg, p11_up_reg, p12_up_reg;
    logic signed [63:0] p22_lo_reg, p22_up_reg;
    logic signed [31:0] a11_1_reg, a22_1_reg, b1_reg, b2_reg;

    // stage 2: sums
    logic signed [64:0] det_reg;
    wide_t n1_reg, n2_reg, bb1_reg, bb2_reg;
    wide_t r1ll_reg, r1ul_reg, r1lu_reg, r1uu_reg;
    wide_t r2ll_reg, r2ul_reg, r2lu_reg, r2uu_reg;
    wide_t m1l_reg, m1u_reg, m2l_reg, m2u_reg;
    logic signed [31:0] a11_2_reg, a22_2_reg;

    // stage 3: compares and det*bound halves
    logic signed [64:0] det3_reg;
    logic               det_zero_reg;
    wide_t n1_3_reg, n2_3_reg, m1l_3_reg, m1u_3_reg, m2l_3_reg, m2u_3_reg;
    logic signed [31:0] a11_3_reg, a22_3_reg;
    logic signed [64:0] dl_lo_reg, dl_hi_reg, du_lo_reg, du_hi_reg;
    logic c1ll_le_reg, c2ll_le_reg, c1ul_lt_reg, c2ul_le_reg;
    logic c1lu_le_reg, c2lu_lt_reg, c1uu_lt_reg, c2uu_lt_reg;

    wide_t bb1, bb2;
    wide_t dl, du;
    logic  unc;
    logic  n2_le_dl, n2_ge_du, n1_le_dl, n1_ge_du;

    assign en               = !v3_reg || !q_stat.full;
    assign subproblem.ready = en;
    assign push             = v3_reg && !q_stat.full;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= subproblem.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            p11_22_reg <= mul_32x32(subproblem.diag_first, subproblem.diag_second);
            p12_12_reg <= mul_32x32(subproblem.off_diag, subproblem.off_diag);
            p22_b1_reg <= mul_32x32(subproblem.diag_second, subproblem.rhs_first);
            p12_b2_reg <= mul_32x32(subproblem.off_diag, subproblem.rhs_second);
            p11_b2_reg <= mul_32x32(subproblem.diag_first, subproblem.rhs_second);
            p12_b1_reg <= mul_32x32(subproblem.off_diag, subproblem.rhs_first);
            p11_lo_reg <= mul_32x32(subproblem.diag_first, lower);
            p12_lo_reg <= mul_32x32(subproblem.off_diag, lower);
            p11_up_reg <= mul_32x32(subproblem.diag_first, upper);
            p12_up_reg <= mul_32x32(subproblem.off_diag, upper);
            p22_lo_reg <= mul_32x32(subproblem.diag_second, lower);
            p22_up_reg <= mul_32x32(subproblem.diag_second, upper);
            a11_1_reg  <= subproblem.diag_first;
            a22_1_reg  <= subproblem.diag_second;
            b1_reg     <= subproblem.rhs_first;
            b2_reg     <= subproblem.rhs_second;
        end
    end

    assign bb1 = WIDE_W'(b1_reg) <<< FRAC_BITS;
    assign bb2 = WIDE_W'(b2_reg) <<< FRAC_BITS;

    always_ff @(posedge clk) begin
        if (en) begin
            det_reg   <= 65'(p11_22_reg) - 65'(p12_12_reg);
            n1_reg    <= WIDE_W'(65'(p22_b1_reg) - 65'(p12_b2_reg)) <<< FRAC_BITS;
            n2_reg    <= WIDE_W'(65'(p11_b2_reg) - 65'(p12_b1_reg)) <<< FRAC_BITS;
            bb1_reg   <= bb1;
            bb2_reg   <= bb2;
            r1ll_reg  <= WIDE_W'(p11_lo_reg) + WIDE_W'(p12_lo_reg);
            r1ul_reg  <= WIDE_W'(p11_up_reg) + WIDE_W'(p12_lo_reg);
            r1lu_reg  <= WIDE_W'(p11_lo_reg) + WIDE_W'(p12_up_reg);
            r1uu_reg  <= WIDE_W'(p11_up_reg) + WIDE_W'(p12_up_reg);
            r2ll_reg  <= WIDE_W'(p12_lo_reg) + WIDE_W'(p22_lo_reg);
            r2ul_reg  <= WIDE_W'(p12_up_reg) + WIDE_W'(p22_lo_reg);
            r2lu_reg  <= WIDE_W'(p12_lo_reg) + WIDE_W'(p22_up_reg);
            r2uu_reg  <= WIDE_W'(p12_up_reg) + WIDE_W'(p22_up_reg);
            m1l_reg   <= bb1 - WIDE_W'(p12_lo_reg);
            m1u_reg   <= bb1 - WIDE_W'(p12_up_reg);
            m2l_reg   <= bb2 - WIDE_W'(p12_lo_reg);
            m2u_reg   <= bb2 - WIDE_W'(p12_up_reg);
            a11_2_reg <= a11_1_reg;
            a22_2_reg <= a22_1_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            det3_reg     <= det_reg;
            det_zero_reg <= (det_reg == '0);
            n1_3_reg     <= n1_reg;
            n2_3_reg     <= n2_reg;
            m1l_3_reg    <= m1l_reg;
            m1u_3_reg    <= m1u_reg;
            m2l_3_reg    <= m2l_reg;
            m2u_3_reg    <= m2u_reg;
            a11_3_reg    <= a11_2_reg;
            a22_3_reg    <= a22_2_reg;
            // det split into an unsigned low half and a signed high half
            dl_lo_reg    <= mul_33x32($signed({1'b0, det_reg[31:0]}), lower);
            dl_hi_reg    <= mul_33x32(det_reg[64:32], lower);
            du_lo_reg    <= mul_33x32($signed({1'b0, det_reg[31:0]}), upper);
            du_hi_reg    <= mul_33x32(det_reg[64:32], upper);
            c1ll_le_reg  <= (bb1_reg <= r1ll_reg);
            c2ll_le_reg  <= (bb2_reg <= r2ll_reg);
            c1ul_lt_reg  <= (bb1_reg <  r1ul_reg);
            c2ul_le_reg  <= (bb2_reg <= r2ul_reg);
            c1lu_le_reg  <= (bb1_reg <= r1lu_reg);
            c2lu_lt_reg  <= (bb2_reg <  r2lu_reg);
            c1uu_lt_reg  <= (bb1_reg <  r1uu_reg);
            c2uu_lt_reg  <= (bb2_reg <  r2uu_reg);
        end
    end

    assign dl       = (WIDE_W'(dl_hi_reg) <<< 32) + WIDE_W'(dl_lo_reg);
    assign du       = (WIDE_W'(du_hi_reg) <<< 32) + WIDE_W'(du_lo_reg);
    assign n2_le_dl = (n2_3_reg <= dl);
    assign n2_ge_du = (n2_3_reg >= du);
    assign n1_le_dl = (n1_3_reg <= dl);
    assign n1_ge_du = (n1_3_reg >= du);
    assign unc      = (lower >= upper);

    // case order: singular, lower >= upper (interior), both lower, x1 free, upper/lower,
    // lower/upper, both upper, x1 free at upper, x2 free at lower, x2 free at upper, else interior
    always_comb begin
        cmd.tag.singular = 1'b0;
        cmd.tag.code     = KKT_INTERIOR;
        cmd.tag.div1     = 1'b1;
        cmd.tag.div2     = 1'b1;
        cmd.tag.x1_fix   = '0;
        cmd.tag.x2_fix   = '0;
        cmd.num1         = n1_3_reg;
        cmd.den1         = det3_reg;
        cmd.num2         = n2_3_reg;
        cmd.den2         = det3_reg;
        priority if (det_zero_reg) begin
            cmd.tag.singular = 1'b1;
            cmd.tag.code     = KKT_LO_LO;
            cmd.tag.div1     = 1'b0;
            cmd.tag.div2     = 1'b0;
        end else if (unc) begin
            cmd.tag.code = KKT_INTERIOR;
        end else if (c1ll_le_reg && c2ll_le_reg) begin
            cmd.tag.code   = KKT_LO_LO;
            cmd.tag.div1   = 1'b0;
            cmd.tag.div2   = 1'b0;
            cmd.tag.x1_fix = lower;
            cmd.tag.x2_fix = lower;
        end else if (!c1ll_le_reg && c1ul_lt_reg && n2_le_dl) begin
            cmd.tag.code   = KKT_FR_LO;
            cmd.tag.div2   = 1'b0;
            cmd.tag.x2_fix = lower;
            cmd.num1       = m1l_3_reg;
            cmd.den1       = DEN_W'(a11_3_reg);
        end else if (!c1ul_lt_reg && c2ul_le_reg) begin
            cmd.tag.code   = KKT_UP_LO;
            cmd.tag.div1   = 1'b0;
            cmd.tag.div2   = 1'b0;
            cmd.tag.x1_fix = upper;
            cmd.tag.x2_fix = lower;
        end else if (c1lu_le_reg && !c2lu_lt_reg) begin
            cmd.tag.code   = KKT_LO_UP;
            cmd.tag.div1   = 1'b0;
            cmd.tag.div2   = 1'b0;
            cmd.tag.x1_fix = lower;
            cmd.tag.x2_fix = upper;
        end else if (!c1uu_lt_reg && !c2uu_lt_reg) begin
            cmd.tag.code   = KKT_UP_UP;
            cmd.tag.div1   = 1'b0;
            cmd.tag.div2   = 1'b0;
            cmd.tag.x1_fix = upper;
            cmd.tag.x2_fix = upper;
        end else if (!c1lu_le_reg && c1uu_lt_reg && n2_ge_du) begin
            cmd.tag.code   = KKT_FR_UP;
            cmd.tag.div2   = 1'b0;
            cmd.tag.x2_fix = upper;
            cmd.num1       = m1u_3_reg;
            cmd.den1       = DEN_W'(a11_3_reg);
        end else if (!c2ll_le_reg && c2lu_lt_reg && n1_le_dl) begin
            cmd.tag.code   = KKT_LO_FR;
            cmd.tag.div1   = 1'b0;
            cmd.tag.x1_fix = lower;
            cmd.num2       = m2l_3_reg;
            cmd.den2       = DEN_W'(a22_3_reg);
        end else if (!c2ul_le_reg && c2uu_lt_reg && n1_ge_du) begin
            cmd.tag.code   = KKT_UP_FR;
            cmd.tag.div1   = 1'b0;
            cmd.tag.x1_fix = upper;
            cmd.num2       = m2u_3_reg;
            cmd.den2       = DEN_W'(a22_3_reg);
        end else begin
            cmd.tag.code = KKT_INTERIOR;
        end
    end

endmodule

// ----- design/bqp_queue.sv -----
`timescale 1ns / 1ps
// bqp_queue: short queue of classified words between front and back
// depends on bqp_pkg

module bqp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bqp_pkg::cmd_t     wr_cmd,
    input  logic              pop,
    output bqp_pkg::cmd_t     rd_cmd,
    output bqp_pkg::q_stat_t  stat
);
    import bqp_pkg::*;

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign stat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_cmd     = mem_reg[rd_ptr_reg];

    always_comb begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) mem_reg[wr_ptr_reg] <= wr_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("queue read while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a write");

endmodule

// ----- design/bqp_div.sv -----
`timescale 1ns / 1ps
// bqp_div: pipelined saturating signed divider, one quotient bit per stage
// depends on bqp_pkg

module bqp_div (
    input  logic                    clk,
    input  logic                    en,
    input  bqp_pkg::wide_t          num,
    input  bqp_pkg::den_t           den,
    output logic [bqp_pkg::DATA_W-1:0] q
);
    import bqp_pkg::*;

    typedef struct packed {
        logic nneg;
        logic neg;
        logic nzero;
        logic dzero;
        logic ovf;
    } flags_t;

    logic [WIDE_W-1:0]    nmag_reg;
    logic [DEN_MAG_W-1:0] dmag_reg;
    flags_t               f0_reg;
    flags_t               f0_chk;

    logic [WIDE_W-1:0]    rem_reg [DIV_STEPS+1];
    logic [DEN_MAG_W-1:0] d_reg   [DIV_STEPS+1];
    logic [DATA_W-1:0]    q_reg   [DIV_STEPS+1];
    flags_t               f_reg   [DIV_STEPS+1];

    logic [DATA_W-1:0]    q_out_reg, q_sat;
    flags_t               ff;
    logic [DATA_W-1:0]    qv;

    // magnitudes
    always_ff @(posedge clk) begin
        if (en) begin
            nmag_reg     <= num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
            dmag_reg     <= den[DEN_W-1] ? DEN_MAG_W'(-den) : DEN_MAG_W'(den);
            f0_reg.nneg  <= num[WIDE_W-1];
            f0_reg.neg   <= num[WIDE_W-1] ^ den[DEN_W-1];
            f0_reg.nzero <= (num == '0);
            f0_reg.dzero <= (den == '0);
            f0_reg.ovf   <= 1'b0;
        end
    end

    // quotient of 2^32 or more saturates
    always_comb begin
        f0_chk     = f0_reg;
        f0_chk.ovf = (nmag_reg >= (WIDE_W'(dmag_reg) << DATA_W));
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rem_reg[0] <= nmag_reg;
            d_reg[0]   <= dmag_reg;
            q_reg[0]   <= '0;
            f_reg[0]   <= f0_chk;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [WIDE_W-1:0] dsh;
        logic              take;

        assign dsh  = WIDE_W'(d_reg[k-1]) << (DIV_STEPS - k);
        assign take = (rem_reg[k-1] >= dsh);

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k] <= take ? rem_reg[k-1] - dsh : rem_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][DATA_W-2:0], take};
                f_reg[k]   <= f_reg[k-1];
            end
        end
    end

    assign ff = f_reg[DIV_STEPS];
    assign qv = q_reg[DIV_STEPS];

    always_comb begin
        priority if (ff.nzero) begin
            q_sat = '0;
        end else if (ff.dzero) begin
            q_sat = ff.nneg ? SAT_NEG : SAT_POS;
        end else if (ff.ovf) begin
            q_sat = ff.neg ? SAT_NEG : SAT_POS;
        end else if (ff.neg) begin
            q_sat = (qv > SAT_NEG) ? SAT_NEG : (~qv + 1'b1);
        end else begin
            q_sat = qv[DATA_W-1] ? SAT_POS : qv;
        end
    end

    always_ff @(posedge clk) begin
        if (en) q_out_reg <= q_sat;
    end

    assign q = q_out_reg;

endmodule

// ----- design/bqp_back.sv -----
`timescale 1ns / 1ps
// bqp_back: pops classified words, runs both divisions and holds the solution word
// depends on bqp_pkg, bqp_ifs and bqp_div

module bqp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bqp_pkg::q_stat_t  q_stat,
    input  bqp_pkg::cmd_t     head,
    output logic              pop,
    bqp_result_if.source      solution
);
    import bqp_pkg::*;

    logic               en;
    logic [DIV_LAT-1:0] vld_reg;
    tag_t               tag_reg [DIV_LAT];
    tag_t               t;
    logic [DATA_W-1:0]  q1, q2;

    assign en  = !vld_reg[DIV_LAT-1] || solution.ready;
    assign pop = en && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_LAT-2:0], !q_stat.empty};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            tag_reg[0] <= head.tag;
            for (int k = 1; k < DIV_LAT; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    bqp_div u_div1 (
        .clk (clk),
        .en  (en),
        .num (head.num1),
        .den (head.den1),
        .q   (q1)
    );

    bqp_div u_div2 (
        .clk (clk),
        .en  (en),
        .num (head.num2),
        .den (head.den2),
        .q   (q2)
    );

    assign t                  = tag_reg[DIV_LAT-1];
    assign solution.valid     = vld_reg[DIV_LAT-1];
    assign solution.x_first   = t.div1 ? q1 : t.x1_fix;
    assign solution.x_second  = t.div2 ? q2 : t.x2_fix;
    assign solution.case_code = t.code;
    assign solution.singular  = t.singular;

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (solution.valid && solution.singular) |->
            (solution.x_first == '0 && solution.x_second == '0
             && solution.case_code == KKT_LO_LO))
        else $error("singular word carries data");
    a_interior_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (solution.valid && !t.singular && t.code == KKT_INTERIOR) |-> (t.div1 && t.div2))
        else $error("interior word without both divisions");
    a_corner_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (solution.valid && (t.code == KKT_UP_LO || t.code == KKT_LO_UP
                            || t.code == KKT_UP_UP)) |-> (!t.div1 && !t.div2))
        else $error("corner word routed through a divider");

endmodule

// ----- tb/bqp_solution_checker.sv -----
`timescale 1ns / 1ps
// bqp_solution_checker: watches the solver channels, predicts each solution and compares
// depends on bqp_pkg and the channel interfaces of bqp_ifs

module bqp_solution_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    bqp_item_if   sub,
    bqp_result_if sol,
    bqp_cfg_if    cfg,
    output int    fails,
    output int    outstanding,
    output int    solved
);
    import bqp_pkg::*;

    typedef logic signed [127:0] acc_t;

    typedef struct packed {
        logic [31:0] x1;
        logic [31:0] x2;
        kkt_t        code;
        logic        singular;
    } solution_t;

    localparam acc_t Q_MAX = 128'sd2147483647;
    localparam acc_t Q_MIN = -128'sd2147483648;

    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    solution_t          pending_solutions[$];

    // truncating divide, saturated to 32 bits
    function automatic logic [31:0] quot_sat(acc_t num, acc_t den);
        acc_t q;
        if (num == 0)
            return '0;
        if (den == 0)
            return (num < 0) ? SAT_NEG : SAT_POS;
        q = num / den;
        if (q > Q_MAX)
            return SAT_POS;
        if (q < Q_MIN)
            return SAT_NEG;
        return q[31:0];
    endfunction

    function automatic solution_t solve_box_qp(logic signed [31:0] s11, logic signed [31:0] s12,
                                               logic signed [31:0] s22, logic signed [31:0] sb1,
                                               logic signed [31:0] sb2, logic signed [31:0] slo,
                                               logic signed [31:0] sup);
        acc_t a11, a12, a22, b1, b2, lo, up, det, bb1, bb2, n1, n2, dl, du;
        acc_t r1ll, r1ul, r1lu, r1uu, r2ll, r2ul, r2lu, r2uu;
        solution_t s;
        a11 = acc_t'(s11); a12 = acc_t'(s12); a22 = acc_t'(s22);
        b1 = acc_t'(sb1); b2 = acc_t'(sb2); lo = acc_t'(slo); up = acc_t'(sup);
        det = a11 * a22 - a12 * a12;
        bb1 = b1 <<< FRAC_BITS;
        bb2 = b2 <<< FRAC_BITS;
        n1 = (a22 * b1 - a12 * b2) <<< FRAC_BITS;
        n2 = (a11 * b2 - a12 * b1) <<< FRAC_BITS;
        dl = det * lo;
        du = det * up;
        // gradient thresholds at the four box corners
        r1ll = a11 * lo + a12 * lo;  r1ul = a11 * up + a12 * lo;
        r1lu = a11 * lo + a12 * up;  r1uu = a11 * up + a12 * up;
        r2ll = a12 * lo + a22 * lo;  r2ul = a12 * up + a22 * lo;
        r2lu = a12 * lo + a22 * up;  r2uu = a12 * up + a22 * up;
        s = '0;
        if (det == 0) begin
            s.singular = 1'b1;
            s.code = KKT_LO_LO;
            return s;
        end
        if (lo >= up) begin
            s.x1 = quot_sat(n1, det); s.x2 = quot_sat(n2, det); s.code = KKT_INTERIOR;
        end else if (bb1 <= r1ll && bb2 <= r2ll) begin
            s.x1 = slo; s.x2 = slo; s.code = KKT_LO_LO;
        end else if (bb1 > r1ll && bb1 < r1ul && n2 <= dl) begin
            s.x1 = quot_sat(bb1 - a12 * lo, a11); s.x2 = slo; s.code = KKT_FR_LO;
        end else if (bb1 >= r1ul && bb2 <= r2ul) begin
            s.x1 = sup; s.x2 = slo; s.code = KKT_UP_LO;
        end else if (bb1 <= r1lu && bb2 >= r2lu) begin
            s.x1 = slo; s.x2 = sup; s.code = KKT_LO_UP;
        end else if (bb1 >= r1uu && bb2 >= r2uu) begin
            s.x1 = sup; s.x2 = sup; s.code = KKT_UP_UP;
        end else if (bb1 > r1lu && bb1 < r1uu && n2 >= du) begin
            s.x1 = quot_sat(bb1 - a12 * up, a11); s.x2 = sup; s.code = KKT_FR_UP;
        end else if (bb2 > r2ll && bb2 < r2lu && n1 <= dl) begin
            s.x1 = slo; s.x2 = quot_sat(bb2 - a12 * lo, a22); s.code = KKT_LO_FR;
        end else if (bb2 > r2ul && bb2 < r2uu && n1 >= du) begin
            s.x1 = sup; s.x2 = quot_sat(bb2 - a12 * up, a22); s.code = KKT_UP_FR;
        end else begin
            s.x1 = quot_sat(n1, det); s.x2 = quot_sat(n2, det); s.code = KKT_INTERIOR;
        end
        return s;
    endfunction

    assign outstanding = pending_solutions.size();

    always @(posedge clk or negedge rst_n) begin
        solution_t want;
        if (!rst_n) begin
            lower_bound <= LOWER_RESET;
            upper_bound <= UPPER_RESET;
            pending_solutions.delete();
            fails  <= 0;
            solved <= 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_LOWER)
                    lower_bound <= cfg.data;
                else if (cfg.index == REG_UPPER)
                    upper_bound <= cfg.data;
            end
            if (sub.valid && sub.ready)
                pending_solutions.push_back(solve_box_qp(sub.diag_first, sub.off_diag,
                    sub.diag_second, sub.rhs_first, sub.rhs_second, lower_bound, upper_bound));
            if (sol.valid && sol.ready) begin
                solved <= solved + 1;
                if (pending_solutions.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected solution word x1=%h x2=%h case=%0d sing=%b",
                                 sol.x_first, sol.x_second, sol.case_code, sol.singular);
                    fails <= fails + 1;
                end else begin
                    want = pending_solutions.pop_front();
                    if (sol.x_first !== want.x1 || sol.x_second !== want.x2
                        || sol.case_code !== want.code || sol.singular !== want.singular) begin
                        if (fails < 10)
                            $display("mismatch: exp x1=%h x2=%h case=%0d sing=%b, got x1=%h x2=%h case=%0d sing=%b",
                                     want.x1, want.x2, want.code, want.singular, sol.x_first,
                                     sol.x_second, sol.case_code, sol.singular);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench: stimulus and verdict for box_qp_two_by_two_solver_unit
// depends on bqp_pkg, bqp_ifs and bqp_solution_checker

module testbench;
    import bqp_pkg::*;

    localparam int   ONE       = 65536;            // 1.0 in q16.16
    localparam int   DRAIN_GAP = 50;               // a bit more than the solver latency
    localparam int   CYCLE_CAP = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // write that must be ignored

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   fails, outstanding, solved;
    int   words_sent = 0;
    int   bound_sets = 0;
    bit   steady = 1'b0;    // no idling on either side while set

    bqp_item_if   sub();
    bqp_result_if sol();
    bqp_cfg_if    cfg();

    box_qp_two_by_two_solver_unit #(.FRAC_BITS(16)) i_dut (
        .clk(clk), .rst_n(rst_n), .subproblem(sub), .solution(sol), .regs(cfg)
    );

    bqp_solution_checker #(.FRAC_BITS(16)) i_checker (
        .clk(clk), .rst_n(rst_n), .sub(sub), .sol(sol), .cfg(cfg),
        .fails(fails), .outstanding(outstanding), .solved(solved)
    );

    always #6 clk = ~clk;

    // hard stop for a hung handshake
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // solution side back-pressure outside steady stretches, ready drawn low with probability 0.17
    always @(negedge clk)
        sol.ready <= steady ? 1'b1 : ($urandom_range(99) >= 17);

    // one subproblem word; valid stays high into the next word unless the sender idles
    task automatic send_word(logic [31:0] a11, logic [31:0] a12, logic [31:0] a22,
                             logic [31:0] b1, logic [31:0] b2);
        sub.valid       = 1'b1;
        sub.diag_first  = a11;
        sub.off_diag    = a12;
        sub.diag_second = a22;
        sub.rhs_first   = b1;
        sub.rhs_second  = b2;
        do @(posedge clk); while (!sub.ready);
        words_sent++;
        @(negedge clk);
        if (!steady && $urandom_range(99) < 17) begin
            sub.valid = 1'b0;
            @(negedge clk);
        end
    endtask

    // wait for every expected solution, then let the pipeline go quiet
    task automatic drain();
        sub.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = value;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic set_bounds(int lo, int up);
        write_reg(REG_LOWER, lo);
        write_reg(REG_UPPER, up);
        bound_sets++;
    endtask

    // an entry drawn from a few regimes: tiny, moderate, extreme or anything
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return $signed($urandom_range(8)) - 4;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(8 * ONE)) - 4 * ONE;
        endcase
    endfunction

    task automatic random_words(int count);
        int k;
        logic [31:0] a11, a12, a22;
        for (int n = 0; n < count; n++) begin
            // a stretch without idling somewhere in each batch
            steady = (n >= count / 3) && (n < count / 3 + 40);
            a11 = pick_value(); a12 = pick_value(); a22 = pick_value();
            if ($urandom_range(99) < 8) begin
                // singular: all entries the same magnitude
                k = $signed($urandom_range(4 * ONE)) - 2 * ONE;
                a11 = k; a22 = k; a12 = $urandom_range(1) ? k : -k;
            end else if ($urandom_range(99) < 45) begin
                // well-posed matrix, diagonal no smaller than the off-diagonal, reaches every kkt case
                a11 = $urandom_range(4 * ONE, ONE / 8);
                a22 = $urandom_range(4 * ONE, ONE / 8);
                a12 = $signed($urandom_range(ONE / 4)) - ONE / 8;
            end
            send_word(a11, a12, a22, pick_value(), pick_value());
        end
        steady = 1'b0;
    endtask

    initial begin
        sub.valid = 1'b0;
        sub.diag_first = '0; sub.off_diag = '0; sub.diag_second = '0;
        sub.rhs_first = '0; sub.rhs_second = '0;
        cfg.valid = 1'b0; cfg.index = REG_LOWER; cfg.data = '0;
        sol.ready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset bounds [0, 1]: identity matrix steers b into each kkt case
        send_word(ONE, 0, ONE, -ONE, -ONE);             // both at lower
        send_word(ONE, 0, ONE, ONE / 2, -ONE);          // x1 free, x2 lower
        send_word(ONE, 0, ONE, 2 * ONE, -ONE);          // upper, lower
        send_word(ONE, 0, ONE, -ONE, ONE / 2);          // lower, x2 free
        send_word(ONE, 0, ONE, ONE / 2, ONE / 2);       // interior
        send_word(ONE, 0, ONE, 2 * ONE, ONE / 2);       // upper, x2 free
        send_word(ONE, 0, ONE, -ONE, 2 * ONE);          // lower, upper
        send_word(ONE, 0, ONE, ONE / 2, 2 * ONE);       // x1 free, upper
        send_word(ONE, 0, ONE, 2 * ONE, 2 * ONE);       // both at upper
        send_word(0, 0, 0, ONE, ONE);                   // zero matrix, singular
        send_word(ONE, ONE, ONE, 3, 5);                 // rank one, singular
        send_word(0, ONE, 0, ONE / 2, ONE / 4);         // zero diagonal, lands on upper, lower
        send_word(0, ONE, 0, 0, 0);                     // zero right side, both at lower
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(1, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000);  // extreme right side lands on upper, lower
        drain();

        // lower >= upper: straight solve, unclamped
        set_bounds(ONE, 0);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);            // ignored index
        send_word(1, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(ONE, 0, ONE, 5 * ONE, -7 * ONE);
        send_word(32'hFFFF_FFFF, 0, 1, 32'h8000_0000, 1);
        random_words(120);
        drain();

        set_bounds(0, ONE);
        random_words(140);
        // hold off until every solution is back, then keep going
        drain();
        random_words(40);
        drain();

        set_bounds(-ONE, ONE);
        random_words(130);
        drain();

        set_bounds(32'h8000_0000, 32'h7FFF_FFFF);
        random_words(110);
        drain();

        set_bounds(32'h7FFF_FFFF, 32'h8000_0000);
        random_words(60);
        drain();

        set_bounds(-3 * ONE, -ONE);
        random_words(120);
        drain();

        set_bounds($urandom, $urandom);
        random_words(160);
        drain();

        $display("solver run: %0d subproblem words over %0d bound settings, %0d solutions compared",
                 words_sent, bound_sets, solved);
        $display("bounds covered reset, reversed, full range and negative boxes");
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
